### design/oal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg
// Shared constants, codes and the cell command type for the ordered array
// list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int FPOS_W   = 4;

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOCATE   = 3'd2;
    localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BOUNDS   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                ins_en;
        logic                del_en;
        logic                clr_en;
        logic [DATA_W-1:0]   value;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    count;
    } cell_cmd_t;

endpackage

### design/oal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: holds an entry, takes its neighbour's entry on a shift,
// loads or zeroes on command and flags a match against the search value.
// ----------------------------------------------------------------------------
module oal_cell (
    input  logic                         clk,
    input  logic [oal_pkg::IDX_W-1:0]    index,
    input  oal_pkg::cell_cmd_t           cmd,
    input  logic [oal_pkg::DATA_W-1:0]   left_value,
    input  logic [oal_pkg::DATA_W-1:0]   right_value,
    output logic [oal_pkg::DATA_W-1:0]   entry,
    output logic [oal_pkg::DATA_W-1:0]   entry_next,
    output logic                         match
);
    import oal_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W-1:0]  idx_inc;

    assign idx_ext = CNT_W'(index);
    assign idx_inc = idx_ext + CNT_W'(1);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en)
        begin
            if (idx_ext == cmd.position)
                entry_next = cmd.value;
            else if (idx_ext > cmd.position && idx_ext <= cmd.count)
                entry_next = left_value;
        end
        else if (cmd.del_en)
        begin
            if (idx_ext >= cmd.position && idx_inc < cmd.count)
                entry_next = right_value;
        end
        else if (cmd.clr_en)
        begin
            if (idx_ext < cmd.count)
                entry_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == cmd.value) && (idx_ext < cmd.count);

endmodule

### design/ordered_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Bounded ordered list held in a row of cells with insert, delete, locate,
// retrieve and clear requests.
// ----------------------------------------------------------------------------
// Each item is worked by all cells at once: every cell shifts, loads or
// compares in parallel, and the result sits in an output register from the
// cycle after the item is accepted. A new item is taken every cycle
// while the output register is empty or being emptied, so the sustained
// rate is one item per cycle, set by the output register handshake.
module ordered_array_list_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [oal_pkg::OP_W-1:0]      opcode,
    input  logic signed [oal_pkg::DATA_W-1:0] item_value,
    input  logic [oal_pkg::POS_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [oal_pkg::ST_W-1:0]      status,
    output logic signed [oal_pkg::DATA_W-1:0] found_value,
    output logic [oal_pkg::FPOS_W-1:0]    found_position,
    output logic [oal_pkg::CNT_W-1:0]     entry_count,
    output logic signed [oal_pkg::DATA_W-1:0] head_value,
    output logic signed [oal_pkg::DATA_W-1:0] tail_value
);
    import oal_pkg::*;

    logic              accept;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cell_cmd_t         cmd;
    logic              ins_ok;
    logic              del_ok;
    logic              pos_ok;

    logic [DATA_W-1:0] cell_entry [CAPACITY];
    logic [DATA_W-1:0] cell_next  [CAPACITY];
    logic [DATA_W-1:0] cell_left  [CAPACITY];
    logic [DATA_W-1:0] cell_right [CAPACITY];
    logic [CAPACITY-1:0] match;

    logic [ST_W-1:0]   status_next;
    logic [DATA_W-1:0] fval_next;
    logic [FPOS_W-1:0] fpos_next;
    logic [DATA_W-1:0] head_next;
    logic [DATA_W-1:0] tail_next;
    logic [IDX_W-1:0]  tail_idx;
    logic [IDX_W-1:0]  loc_idx;
    logic              loc_hit;

    logic [ST_W-1:0]   status_reg;
    logic [DATA_W-1:0] fval_reg;
    logic [FPOS_W-1:0] fpos_reg;
    logic [CNT_W-1:0]  ecount_reg;
    logic [DATA_W-1:0] head_reg;
    logic [DATA_W-1:0] tail_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign ins_ok = (position <= count_reg) && (count_reg < CNT_W'(CAPACITY));
    assign del_ok = (position < count_reg);
    assign pos_ok = (position < count_reg);

    always_comb
    begin
        cmd.ins_en   = accept && (opcode == OP_INSERT) && ins_ok;
        cmd.del_en   = accept && (opcode == OP_DELETE) && del_ok;
        cmd.clr_en   = accept && (opcode == OP_CLEAR);
        cmd.value    = item_value;
        cmd.position = position;
        cmd.count    = count_reg;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign cell_left[g] = '0;
            end
            else
            begin : g_mid_l
                assign cell_left[g] = cell_entry[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign cell_right[g] = '0;
            end
            else
            begin : g_mid_r
                assign cell_right[g] = cell_entry[g+1];
            end

            oal_cell u_cell (
                .clk         (clk),
                .index       (IDX_W'(g)),
                .cmd         (cmd),
                .left_value  (cell_left[g]),
                .right_value (cell_right[g]),
                .entry       (cell_entry[g]),
                .entry_next  (cell_next[g]),
                .match       (match[g])
            );
        end
    endgenerate

    // first matching cell
    always_comb
    begin
        loc_idx = '0;
        loc_hit = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                loc_idx = IDX_W'(i);
                loc_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        fval_next   = '0;
        fpos_next   = '0;
        count_next  = count_reg;
        case (opcode)
            OP_INSERT:
            begin
                if (position > count_reg)
                    status_next = ST_BOUNDS;
                else if (!ins_ok)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            OP_DELETE:
            begin
                if (!del_ok)
                    status_next = ST_BOUNDS;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            OP_LOCATE:
            begin
                if (loc_hit)
                    fpos_next = FPOS_W'(loc_idx);
                else
                    status_next = ST_NOTFOUND;
            end
            OP_RETRIEVE:
            begin
                if (!pos_ok)
                    status_next = ST_BOUNDS;
                else
                    fval_next = cell_entry[position[IDX_W-1:0]];
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign tail_idx  = IDX_W'(count_next - CNT_W'(1));
    assign head_next = (count_next != '0) ? cell_next[0] : '0;
    assign tail_next = (count_next != '0) ? cell_next[tail_idx] : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            fval_reg   <= fval_next;
            fpos_reg   <= fpos_next;
            ecount_reg <= count_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_value    = fval_reg;
    assign found_position = fpos_reg;
    assign entry_count    = ecount_reg;
    assign head_value     = head_reg;
    assign tail_value     = tail_reg;

endmodule

### sim/oal_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_list_checker
// Shadow model and result checker for the ordered array list engine.
// ----------------------------------------------------------------------------
// Watches both channels at the rising edge. Every accepted request is run
// through a shadow copy of the list (cells and count), and the result it
// should give is queued. Every accepted result is compared field by field
// with the oldest queued one. Mismatches, results with nothing queued and
// the number of results still owed are handed to the testbench top.
module oal_list_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [oal_pkg::OP_W-1:0]          opcode,
    input  logic signed [oal_pkg::DATA_W-1:0] item_value,
    input  logic [oal_pkg::POS_W-1:0]         position,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [oal_pkg::ST_W-1:0]          status,
    input  logic signed [oal_pkg::DATA_W-1:0] found_value,
    input  logic [oal_pkg::FPOS_W-1:0]        found_position,
    input  logic [oal_pkg::CNT_W-1:0]         entry_count,
    input  logic signed [oal_pkg::DATA_W-1:0] head_value,
    input  logic signed [oal_pkg::DATA_W-1:0] tail_value,
    output int                                error_count,
    output int                                pending
);
    import oal_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] found_value;
        logic [FPOS_W-1:0] found_position;
        logic [CNT_W-1:0]  entry_count;
        logic [DATA_W-1:0] head_value;
        logic [DATA_W-1:0] tail_value;
    } list_result_t;

    logic [DATA_W-1:0] shadow_cells [CAPACITY];
    logic [CNT_W-1:0]  shadow_count;
    list_result_t      expected_results [$];

    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        int           i;
        logic         hit;
        r        = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (int'(pos) > int'(shadow_count))
                begin
                    r.status = ST_BOUNDS;
                end
                else if (int'(shadow_count) >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (i = int'(shadow_count); i > int'(pos); i--)
                    begin
                        shadow_cells[i] = shadow_cells[i-1];
                    end
                    shadow_cells[pos] = val;
                    shadow_count      = shadow_count + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (int'(pos) >= int'(shadow_count))
                begin
                    r.status = ST_BOUNDS;
                end
                else
                begin
                    for (i = int'(pos); i + 1 < int'(shadow_count); i++)
                    begin
                        shadow_cells[i] = shadow_cells[i+1];
                    end
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_LOCATE:
            begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < int'(shadow_count); i++)
                begin
                    if (!hit && shadow_cells[i] == val)
                    begin
                        hit              = 1'b1;
                        r.status         = ST_OK;
                        r.found_position = i[FPOS_W-1:0];
                    end
                end
            end
            OP_RETRIEVE:
            begin
                if (int'(pos) >= int'(shadow_count))
                begin
                    r.status = ST_BOUNDS;
                end
                else
                begin
                    r.found_value = shadow_cells[pos];
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < int'(shadow_count); i++)
                begin
                    shadow_cells[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = shadow_count;
        if (shadow_count != 0)
        begin
            r.head_value = shadow_cells[0];
            r.tail_value = shadow_cells[shadow_count - 1'b1];
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        list_result_t fresh;
        if (!rst_n)
        begin
            shadow_count = '0;
            foreach (shadow_cells[i])
            begin
                shadow_cells[i] = '0;
            end
            expected_results.delete();
            error_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result with no request owed, expected none, actual status %0h",
                             $time, status);
                    error_count++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("found_value", want.found_value, found_value);
                    check_field("found_position", 32'(want.found_position),
                                32'(found_position));
                    check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                    check_field("head_value", want.head_value, head_value);
                    check_field("tail_value", want.tail_value, tail_value);
                end
            end
            if (in_valid && in_ready)
            begin
                fresh            = apply_list_op(opcode, item_value, position);
                expected_results = {expected_results, fresh};
            end
        end
        pending = expected_results.size();
    end

endmodule

### sim/tb_ordered_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_engine
// Stimulus and verdict for the ordered array list engine.
// ----------------------------------------------------------------------------
// A directed run covers the empty list, bad positions, append and front
// insert, extreme values, hit and miss searches, clear and the unused
// opcodes. Four random phases follow: growth until the store is full,
// draining, a mixed phase with no idling on either side, and growth again.
// Positions lean towards the head of the list so that most requests are
// legal, with some past the end. Values come partly from a small pool so
// that searches hit. The receiver is held off for long stretches twice,
// and the sender waits for all results between phases.
module tb_ordered_array_list_engine;
    import oal_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int PHASE_ITEMS    = 150;
    localparam int IDLE_PERCENT   = 20;
    localparam int TX_GAP_PERCENT = 10;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] found_value;
    logic [FPOS_W-1:0]        found_position;
    logic [CNT_W-1:0]         entry_count;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;

    int   error_count;
    int   pending;
    logic tx_idle_on;
    logic rx_idle_on;
    int   hold_requests;

    ordered_array_list_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .item_value     (item_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_value    (found_value),
        .found_position (found_position),
        .entry_count    (entry_count),
        .head_value     (head_value),
        .tail_value     (tail_value)
    );

    oal_list_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .item_value     (item_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_value    (found_value),
        .found_position (found_position),
        .entry_count    (entry_count),
        .head_value     (head_value),
        .tail_value     (tail_value),
        .error_count    (error_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random back-pressure, plus long hold-offs on request
    initial
    begin
        int holds_taken;
        holds_taken = 0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_taken != hold_requests)
            begin
                holds_taken++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_ready <= rx_idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        int gap;
        if (tx_idle_on && $urandom_range(99) < TX_GAP_PERCENT)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        opcode     <= op;
        item_value <= val;
        position   <= pos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] pool [6];
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h7FFF_FFFF;
        pool[3] = 32'h8000_0000;
        pool[4] = 32'h0000_0001;
        pool[5] = 32'h5A5A_5A5A;
        if ($urandom_range(99) < 40)
        begin
            return pool[$urandom_range(5)];
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            return POS_W'($urandom_range(3));
        end
        if (roll < 85)
        begin
            return POS_W'($urandom_range(CAPACITY));
        end
        return POS_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int ins_w, input int del_w);
        int roll;
        roll = $urandom_range(99);
        if (roll < ins_w)
        begin
            return OP_INSERT;
        end
        if (roll < ins_w + del_w)
        begin
            return OP_DELETE;
        end
        roll = $urandom_range(99);
        if (roll < 45)
        begin
            return OP_LOCATE;
        end
        if (roll < 85)
        begin
            return OP_RETRIEVE;
        end
        if (roll < 93)
        begin
            return OP_CLEAR;
        end
        // unused opcodes above clear
        return OP_CLEAR + OP_W'(1 + $urandom_range(2));
    endfunction

    initial
    begin : stimulus
        int ins_w [4];
        int del_w [4];
        int ph;
        int n;
        ins_w = '{55, 15, 35, 60};
        del_w = '{10, 50, 30, 10};

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_INSERT;
        item_value    = '0;
        position      = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_requests = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list
        send_item(OP_RETRIEVE, 32'h0, 5'd0);
        send_item(OP_DELETE, 32'h0, 5'd0);
        send_item(OP_LOCATE, 32'h0, 5'd0);
        send_item(OP_CLEAR, 32'h0, 5'd0);
        send_item(OP_INSERT, 32'h1, 5'd1);
        send_item(OP_INSERT, 32'h1, 5'd31);
        // build -1, 0, max, min
        send_item(OP_INSERT, 32'h7FFF_FFFF, 5'd0);
        send_item(OP_INSERT, 32'h8000_0000, 5'd1);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_INSERT, 32'h0000_0000, 5'd1);
        send_item(OP_LOCATE, 32'h8000_0000, 5'd0);
        send_item(OP_LOCATE, 32'h1234_5678, 5'd0);
        send_item(OP_RETRIEVE, 32'h0, 5'd3);
        send_item(OP_RETRIEVE, 32'h0, 5'd4);
        send_item(OP_RETRIEVE, 32'h0, 5'd16);
        send_item(OP_CLEAR + 3'd1, $urandom, 5'd31);
        send_item(OP_CLEAR + 3'd2, $urandom, 5'd0);
        send_item(OP_CLEAR + 3'd3, $urandom, 5'd16);
        send_item(OP_DELETE, 32'h0, 5'd4);
        send_item(OP_DELETE, 32'h0, 5'd0);
        send_item(OP_DELETE, 32'h0, 5'd2);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_LOCATE, 32'h0, 5'd0);
        send_item(OP_INSERT, 32'h5A5A_5A5A, 5'd2);
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((ph == 0 && n == 60) || (ph == 3 && n == 30))
                begin
                    hold_requests++;
                end
                send_item(pick_op(ins_w[ph], del_w[ph]), pick_value(), pick_position());
            end
            wait_drained();
        end

        repeat (4) @(negedge clk);
        if (error_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
